// ----- sv/mcm_pkg.sv -----
// Shared types, constants and the square-root fraction table of the MIDI CC macro mapper.
// Used by the value lane, the output chain cell and the top level; depends on nothing.
`default_nettype none

package mcm_pkg;

    localparam int NUM_SLOTS_DEF = 6;

    localparam int ITEM_W     = 38;
    localparam int TDATA_W    = 40;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 28;
    localparam int MAP_W      = 28;

    localparam logic [CFG_IDX_W-1:0] CFG_LISTEN_CC      = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LISTEN_CHANNEL = 8'd1;
    localparam int                   CFG_MAP_BASE       = 2;

    localparam logic [6:0]       LISTEN_CC_RESET      = 7'd1;
    localparam logic [4:0]       LISTEN_CHANNEL_RESET = 5'd0;
    localparam logic [4:0]       LISTEN_ANY           = 5'd0;
    localparam logic [MAP_W-1:0] MAP_RESET            = 28'h3F80002;
    localparam logic [3:0]       CC_STATUS_HI         = 4'hB;
    localparam logic [6:0]       VALUE_MAX            = 7'd127;

    // Interpolation denominators, doubled divisors and reciprocals for rounding.
    localparam int               DEN_W    = 17;
    localparam logic [16:0]      DEN_LIN  = 17'd127;
    localparam logic [16:0]      DEN_SQ   = 17'd16129;
    localparam logic [16:0]      DEN_ROOT = 17'd65536;
    localparam logic [14:0]      DIV_LIN  = 15'd254;
    localparam logic [14:0]      DIV_SQ   = 15'd32258;
    localparam logic [14:0]      K_LIN    = 15'd129;
    localparam logic [14:0]      K_SQ     = 15'd130;
    localparam int               S_LIN    = 15;
    localparam int               S_SQ     = 22;
    localparam int               S_ROOT   = 17;

    typedef enum logic [1:0] {
        CURVE_LINEAR     = 2'd0,
        CURVE_SQUARE     = 2'd1,
        CURVE_ROOT       = 2'd2,
        CURVE_LINEAR_ALT = 2'd3
    } t_curve;

    typedef struct packed {
        t_curve     curve;
        logic [6:0] mx;
        logic [6:0] mn;
        logic [3:0] ch;
        logic [6:0] cc;
        logic       en;
    } t_map;

    typedef struct packed {
        logic [15:0] tm;
        logic [6:0]  d2;
        logic [6:0]  d1;
        logic [7:0]  status;
    } t_item;

    typedef struct packed {
        logic  last;
        logic  gen;
        t_item item;
    } t_result;

    typedef struct packed {
        logic    vld;
        t_result res;
    } t_cell;

    localparam int ROOT_ENTRIES = 128;
    typedef logic [15:0] t_root_table [ROOT_ENTRIES];

    // round(65536 * sqrt(x / 127)) by integer search, saturated to 16 bits.
    function automatic t_root_table build_root_table();
        t_root_table tab;
        logic [63:0] lim;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mid;
        logic [63:0] t;
        for (int x = 0; x < ROOT_ENTRIES; x++) begin
            lim = 64'(x) << 34;
            lo  = 64'd0;
            hi  = 64'd65536;
            for (int it = 0; it < 18; it++) begin
                if (lo < hi) begin
                    mid = (lo + hi + 64'd1) >> 1;
                    t   = (mid << 1) - 64'd1;
                    if (t * t * 64'd127 <= lim) begin
                        lo = mid;
                    end else begin
                        hi = mid - 64'd1;
                    end
                end
            end
            if (lo > 64'd65535) begin
                lo = 64'd65535;
            end
            tab[x] = 16'(lo);
        end
        return tab;
    endfunction

    localparam t_root_table ROOT_TABLE = build_root_table();

endpackage

`default_nettype wire

// ----- sv/midi_cc_macro_mapper.sv -----
// Top level of the MIDI CC macro mapper: configuration registers, input pipeline,
// value lanes and the output chain. Depends on mcm_pkg, mcm_lane and mcm_cell.
//
// Each accepted message comes out first unchanged, followed, when it is a control change on the
// listened controller and channel, by one generated control change per enabled slot in slot
// order; the final result of a message carries tlast. Each message passes the input pipeline and
// the value lanes before its results are loaded into a chain of NUM_SLOTS + 1 cells, which they
// leave at one per cycle while m_axis_tready is high. A message is loaded only when the chain
// holds no other result but possibly one leaving its head cell, so the chain sets the sustained
// message rate. A new message is accepted while earlier results still wait in the chain.
`default_nettype none

module midi_cc_macro_mapper
    import mcm_pkg::*;
#(
    parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // status_byte[7:0], data_one[14:8], data_two[21:15], time_offset[37:22], zeros[39:38]
    input  wire logic [TDATA_W-1:0]    s_axis_tdata,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // out_status[7:0], out_data_one[14:8], out_data_two[21:15], out_time_offset[37:22],
    // zeros[39:38]
    output logic [TDATA_W-1:0]         m_axis_tdata,
    // is_generated[0]
    output logic                       m_axis_tuser,
    output logic                       m_axis_tlast
);

    localparam int NUM_CELLS  = NUM_SLOTS + 1;
    localparam int PIPE_DEPTH = 5;
    localparam int PIPE_LAST  = PIPE_DEPTH - 1;

    logic [6:0]            r_listen_cc;
    logic [4:0]            r_listen_channel;
    t_map                  r_map [NUM_SLOTS];

    logic [PIPE_DEPTH-1:0] r_vld;
    t_item                 r_item [PIPE_DEPTH];
    logic [13:0]           r_sq;
    logic [15:0]           r_root;
    logic [6:0]            lane_val [NUM_SLOTS];

    t_item                 c_in_item;
    logic                  c_en;
    logic                  c_load;
    logic                  c_chain_ready;
    logic                  c_rest_busy;
    logic                  c_hit;
    logic                  c_later;
    t_cell                 c_load_cell [NUM_CELLS];
    t_cell                 cell_q [NUM_CELLS];
    t_cell                 cell_up [NUM_CELLS];
    logic                  cell_free [NUM_CELLS];
    logic                  cell_down [NUM_CELLS];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_listen_cc      <= LISTEN_CC_RESET;
            r_listen_channel <= LISTEN_CHANNEL_RESET;
            for (int k = 0; k < NUM_SLOTS; k++) begin
                r_map[k] <= t_map'(MAP_RESET);
            end
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == CFG_LISTEN_CC) begin
                r_listen_cc <= i_cfg_data[6:0];
            end
            if (i_cfg_index == CFG_LISTEN_CHANNEL) begin
                r_listen_channel <= i_cfg_data[4:0];
            end
            for (int k = 0; k < NUM_SLOTS; k++) begin
                if (i_cfg_index == CFG_IDX_W'(CFG_MAP_BASE + k)) begin
                    r_map[k] <= t_map'(i_cfg_data[MAP_W-1:0]);
                end
            end
        end
    end

    assign c_in_item     = t_item'(s_axis_tdata[ITEM_W-1:0]);
    assign c_chain_ready = cell_free[0] && !c_rest_busy;
    assign c_en          = !r_vld[PIPE_LAST] || c_chain_ready;
    assign c_load        = r_vld[PIPE_LAST] && c_chain_ready;
    assign s_axis_tready = c_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (c_en) begin
            r_vld <= {r_vld[PIPE_DEPTH-2:0], s_axis_tvalid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_en) begin
            r_item[0] <= c_in_item;
            for (int k = 1; k < PIPE_DEPTH; k++) begin
                r_item[k] <= r_item[k-1];
            end
            r_sq   <= 14'(r_item[0].d2) * 14'(r_item[0].d2);
            r_root <= ROOT_TABLE[r_item[0].d2];
        end
    end

    for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_lane
        mcm_lane u_lane (
            .i_clk   (i_clk),
            .i_en    (c_en),
            .i_map   (r_map[g]),
            .i_x     (r_item[1].d2),
            .i_sq    (r_sq),
            .i_root  (r_root),
            .o_value (lane_val[g])
        );
    end

    always_comb begin
        c_hit = (r_item[PIPE_LAST].status[7:4] == CC_STATUS_HI)
             && (r_item[PIPE_LAST].d1 == r_listen_cc)
             && ((r_listen_channel == LISTEN_ANY)
              || (5'({1'b0, r_item[PIPE_LAST].status[3:0]}) + 5'd1 == r_listen_channel));
        c_load_cell[0].vld      = 1'b1;
        c_load_cell[0].res.gen  = 1'b0;
        c_load_cell[0].res.last = 1'b0;
        c_load_cell[0].res.item = r_item[PIPE_LAST];
        for (int s = 0; s < NUM_SLOTS; s++) begin
            c_load_cell[s+1].vld              = c_hit && r_map[s].en;
            c_load_cell[s+1].res.gen          = 1'b1;
            c_load_cell[s+1].res.last         = 1'b0;
            c_load_cell[s+1].res.item.status  = {CC_STATUS_HI, r_map[s].ch};
            c_load_cell[s+1].res.item.d1      = r_map[s].cc;
            c_load_cell[s+1].res.item.d2      = lane_val[s];
            c_load_cell[s+1].res.item.tm      = r_item[PIPE_LAST].tm;
        end
        c_later = 1'b0;
        for (int k = NUM_CELLS - 1; k >= 0; k--) begin
            c_load_cell[k].res.last = c_load_cell[k].vld && !c_later;
            c_later                 = c_later || c_load_cell[k].vld;
        end
    end

    for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
        if (g == 0) begin : g_head
            assign cell_down[g] = m_axis_tready;
        end else begin : g_body
            assign cell_down[g] = cell_free[g-1];
        end
        if (g == NUM_CELLS - 1) begin : g_tail
            assign cell_up[g] = '0;
        end else begin : g_link
            assign cell_up[g] = cell_q[g+1];
        end
        mcm_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_load      (c_load),
            .i_load_cell (c_load_cell[g]),
            .i_up        (cell_up[g]),
            .i_down_free (cell_down[g]),
            .o_cell      (cell_q[g]),
            .o_free      (cell_free[g])
        );
    end

    always_comb begin
        c_rest_busy = 1'b0;
        for (int k = 1; k < NUM_CELLS; k++) begin
            c_rest_busy = c_rest_busy || cell_q[k].vld;
        end
    end

    assign m_axis_tvalid = cell_q[0].vld;
    assign m_axis_tdata  = TDATA_W'(cell_q[0].res.item);
    assign m_axis_tuser  = cell_q[0].res.gen;
    assign m_axis_tlast  = cell_q[0].res.last;

    a_more_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |-> c_rest_busy)
        else $error("Non-final transfer with no further result in the chain.");

    a_last_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> !c_rest_busy)
        else $error("Final result at the output while the chain still holds results.");

    a_gen_is_cc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[7:4] == CC_STATUS_HI))
        else $error("Generated result is not a control change.");

endmodule

`default_nettype wire

// ----- sv/mcm_lane.sv -----
// One value lane: maps a controller value through a slot's curve and range in three stages.
// Depends on mcm_pkg for the map word layout and the rounding constants.
`default_nettype none

module mcm_lane
    import mcm_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_en,
    input  wire t_map        i_map,
    input  wire logic [6:0]  i_x,
    input  wire logic [13:0] i_sq,
    input  wire logic [15:0] i_root,
    output logic      [6:0]  o_value
);

    t_curve              c_kind;
    logic [15:0]         c_w;
    logic [DEN_W-1:0]    c_den;
    logic signed [7:0]   c_d;
    logic signed [24:0]  c_prod;
    logic [23:0]         c_base;
    logic [25:0]         c_num;
    logic [23:0]         n_m;
    logic [23:0]         r_m;
    t_curve              r_kind_c;

    logic [14:0]         d_k;
    logic [36:0]         d_p;
    logic [7:0]          n_qe;
    logic [7:0]          r_qe;
    logic [21:0]         r_m_d;
    t_curve              r_kind_d;

    logic [14:0]         e_div;
    logic [22:0]         e_prod;
    logic [22:0]         e_rem;
    logic [7:0]          e_q;
    logic [6:0]          n_value;
    logic [6:0]          r_value;

    // The numerator never goes negative because the weight never exceeds the denominator.
    always_comb begin
        case (i_map.curve)
            CURVE_SQUARE: begin
                c_kind = CURVE_SQUARE;
                c_w    = {2'b00, i_sq};
                c_den  = DEN_SQ;
            end
            CURVE_ROOT: begin
                c_kind = CURVE_ROOT;
                c_w    = i_root;
                c_den  = DEN_ROOT;
            end
            default: begin
                c_kind = CURVE_LINEAR;
                c_w    = {9'd0, i_x};
                c_den  = DEN_LIN;
            end
        endcase
        c_d    = $signed({1'b0, i_map.mx}) - $signed({1'b0, i_map.mn});
        c_prod = $signed({1'b0, c_w}) * c_d;
        c_base = 24'(i_map.mn) * 24'(c_den);
        c_num  = {2'b00, c_base} + {c_prod[24], c_prod};
        n_m    = {c_num[22:0], 1'b0} + 24'(c_den);
    end

    always_comb begin
        d_k = (r_kind_c == CURVE_SQUARE) ? K_SQ : K_LIN;
        d_p = 37'(r_m[21:0]) * 37'(d_k);
        case (r_kind_c)
            CURVE_SQUARE: n_qe = 8'(d_p >> S_SQ);
            CURVE_ROOT:   n_qe = 8'(r_m >> S_ROOT);
            default:      n_qe = 8'(d_p >> S_LIN);
        endcase
    end

    always_comb begin
        e_div  = (r_kind_d == CURVE_SQUARE) ? DIV_SQ : DIV_LIN;
        e_prod = 23'(r_qe) * 23'(e_div);
        e_rem  = {1'b0, r_m_d} - e_prod;
        e_q    = r_qe;
        if ((r_kind_d != CURVE_ROOT) && (e_rem >= 23'(e_div))) begin
            e_q = r_qe + 8'd1;
        end
        n_value = (e_q > 8'(VALUE_MAX)) ? VALUE_MAX : e_q[6:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m      <= n_m;
            r_kind_c <= c_kind;
            r_qe     <= n_qe;
            r_m_d    <= r_m[21:0];
            r_kind_d <= r_kind_c;
            r_value  <= n_value;
        end
    end

    assign o_value = r_value;

endmodule

`default_nettype wire

// ----- sv/mcm_cell.sv -----
// One cell of the output chain: holds one result and passes it toward the output port.
// Depends on mcm_pkg for the cell and result types.
`default_nettype none

module mcm_cell
    import mcm_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_load,
    input  wire t_cell i_load_cell,
    input  wire t_cell i_up,
    input  wire logic  i_down_free,
    output t_cell      o_cell,
    output logic       o_free
);

    logic    r_vld;
    logic    n_vld;
    t_result r_res;
    t_result n_res;

    // The cell is empty or hands its result on, so it may take its upstream neighbor's.
    assign o_free = !r_vld | i_down_free;

    always_comb begin
        n_vld = r_vld;
        n_res = r_res;
        if (i_load) begin
            n_vld = i_load_cell.vld;
            n_res = i_load_cell.res;
        end else if (o_free) begin
            n_vld = i_up.vld;
            n_res = i_up.res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_cell = '{vld: r_vld, res: r_res};

endmodule

`default_nettype wire

// ----- bench/midi_cc_macro_mapper_tb.sv -----
// Self-checking testbench for midi_cc_macro_mapper: directed and random MIDI traffic
// under several register settings, checked against a predictor of the value mapping.
// Depends on mcm_pkg and midi_cc_macro_mapper only.
`default_nettype none

module midi_cc_macro_mapper_tb
    import mcm_pkg::*;
();

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [TDATA_W-1:0]    s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [TDATA_W-1:0]    m_axis_tdata;
    logic                  m_axis_tuser;
    logic                  m_axis_tlast;

    midi_cc_macro_mapper dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Register image kept by the predictor.
    logic [6:0] listen_cc_q;
    logic [4:0] listen_ch_q;
    t_map       slot_map [NUM_SLOTS_DEF];

    t_result pending_results [$];

    int snd_idle_pct = 0;
    int rcv_stall_pct = 0;
    int mismatch_count = 0;
    int message_count = 0;
    int macro_count = 0;
    int setting_count = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= rcv_stall_pct);
    end

    initial begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    function automatic longint round_half_away(longint n, longint den);
        if (n >= 0) begin
            return (2 * n + den) / (2 * den);
        end
        return -((2 * (-n) + den) / (2 * den));
    endfunction

    // Largest r with (2r-1)^2 * 127 <= x * 2^34, i.e. round(65536 * sqrt(x / 127)).
    function automatic longint root_fraction(int x);
        longint r;
        longint lim;
        lim = longint'(x) << 34;
        r = longint'($rtoi(65536.0 * $sqrt(x / 127.0) + 0.5));
        while (r > 0 && (2 * r - 1) * (2 * r - 1) * 127 > lim) begin
            r--;
        end
        while (r < 65536 && (2 * r + 1) * (2 * r + 1) * 127 <= lim) begin
            r++;
        end
        if (r > 65535) begin
            r = 65535;
        end
        return r;
    endfunction

    function automatic logic [6:0] scaled_value(t_map m, logic [6:0] x);
        longint lo;
        longint span;
        longint xv;
        longint r;
        lo = longint'(m.mn);
        span = longint'(m.mx) - lo;
        xv = longint'(x);
        case (m.curve)
            CURVE_SQUARE: r = round_half_away(lo * 16129 + xv * xv * span, 16129);
            CURVE_ROOT:   r = round_half_away(lo * 65536 + root_fraction(int'(x)) * span, 65536);
            default:      r = round_half_away(lo * 127 + xv * span, 127);
        endcase
        if (r < 0) begin
            r = 0;
        end
        if (r > 127) begin
            r = 127;
        end
        return 7'(r);
    endfunction

    function automatic void predict_message(t_item msg);
        t_result res;
        logic    hit;
        res.item = msg;
        res.gen  = 1'b0;
        res.last = 1'b1;
        pending_results.push_back(res);
        message_count++;
        hit = (msg.status[7:4] == CC_STATUS_HI) && (msg.d1 == listen_cc_q) &&
              (listen_ch_q == LISTEN_ANY || 5'(msg.status[3:0]) + 5'd1 == listen_ch_q);
        if (!hit) begin
            return;
        end
        for (int s = 0; s < NUM_SLOTS_DEF; s++) begin
            if (slot_map[s].en) begin
                pending_results[pending_results.size() - 1].last = 1'b0;
                res.item.status = {CC_STATUS_HI, slot_map[s].ch};
                res.item.d1     = slot_map[s].cc;
                res.item.d2     = scaled_value(slot_map[s], msg.d2);
                res.item.tm     = msg.tm;
                res.gen         = 1'b1;
                res.last        = 1'b1;
                pending_results.push_back(res);
            end
        end
    endfunction

    task automatic flag_mismatch(string what);
        mismatch_count++;
        if (mismatch_count <= 50) begin
            $display("%0t: mismatch: %s", $realtime, what);
        end
    endtask

    task automatic compare_field(string name, logic [15:0] got, logic [15:0] want);
        if (got !== want) begin
            flag_mismatch($sformatf("%s got %0h want %0h", name, got, want));
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_result want;
        t_item   got;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            predict_message(t_item'(s_axis_tdata[ITEM_W-1:0]));
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_item'(m_axis_tdata[ITEM_W-1:0]);
            if (pending_results.size() == 0) begin
                flag_mismatch($sformatf("unexpected transfer %0h", m_axis_tdata));
            end else begin
                want = pending_results.pop_front();
                if (want.gen) begin
                    macro_count++;
                end
                compare_field("out_status", 16'(got.status), 16'(want.item.status));
                compare_field("out_data_one", 16'(got.d1), 16'(want.item.d1));
                compare_field("out_data_two", 16'(got.d2), 16'(want.item.d2));
                compare_field("out_time_offset", got.tm, want.item.tm);
                compare_field("tdata padding", 16'(m_axis_tdata[TDATA_W-1:ITEM_W]), 16'd0);
                compare_field("is_generated", 16'(m_axis_tuser), 16'(want.gen));
                compare_field("last_of_run", 16'(m_axis_tlast), 16'(want.last));
            end
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        if (idx == CFG_LISTEN_CC) begin
            listen_cc_q = data[6:0];
        end else if (idx == CFG_LISTEN_CHANNEL) begin
            listen_ch_q = data[4:0];
        end else if (idx >= CFG_MAP_BASE && idx < CFG_MAP_BASE + NUM_SLOTS_DEF) begin
            slot_map[idx - CFG_MAP_BASE] = t_map'(data);
        end
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic write_map(int slot, t_map m);
        write_reg(CFG_IDX_W'(CFG_MAP_BASE + slot), CFG_DATA_W'(m));
    endtask

    function automatic t_map make_map(logic en, logic [6:0] cc, logic [3:0] ch,
                                      logic [6:0] mn, logic [6:0] mx, t_curve curve);
        t_map m;
        m.en    = en;
        m.cc    = cc;
        m.ch    = ch;
        m.mn    = mn;
        m.mx    = mx;
        m.curve = curve;
        return m;
    endfunction

    task automatic send_msg(logic [7:0] status, logic [6:0] d1, logic [6:0] d2,
                            logic [15:0] tm);
        t_item msg;
        msg.status = status;
        msg.d1     = d1;
        msg.d2     = d2;
        msg.tm     = tm;
        @(negedge i_clk);
        while ($urandom_range(99) < snd_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= TDATA_W'(msg);
        @(posedge i_clk);
        while (!s_axis_tready) begin
            @(posedge i_clk);
        end
    endtask

    // Drop the input stream and let every expected transfer drain before a register write.
    task automatic settle();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (16) @(posedge i_clk);
        setting_count++;
    endtask

    task automatic test_pass_through();
        send_msg(8'hB0, 7'd1, 7'd64, 16'h1234);
        send_msg(8'h00, 7'd0, 7'd0, 16'h0000);
        send_msg(8'h7F, 7'd127, 7'd127, 16'hFFFF);
        send_msg(8'h80, 7'd1, 7'd5, 16'h8001);
        send_msg(8'hFF, 7'd1, 7'd127, 16'h7FFE);
    endtask

    task automatic test_curve_shapes();
        settle();
        write_reg(CFG_LISTEN_CC, 28'hFFFFFFF);
        write_reg(CFG_LISTEN_CHANNEL, 28'd0);
        write_map(0, make_map(1'b1, 7'd0, 4'd0, 7'd0, 7'd127, CURVE_LINEAR));
        write_map(1, make_map(1'b1, 7'd127, 4'd15, 7'd0, 7'd127, CURVE_SQUARE));
        write_map(2, make_map(1'b1, 7'd64, 4'd7, 7'd0, 7'd127, CURVE_ROOT));
        write_map(3, make_map(1'b1, 7'd21, 4'd8, 7'd10, 7'd100, CURVE_LINEAR_ALT));
        write_map(4, make_map(1'b1, 7'd42, 4'd3, 7'd127, 7'd0, CURVE_ROOT));
        write_map(5, make_map(1'b1, 7'd85, 4'd12, 7'd127, 7'd0, CURVE_SQUARE));
        send_msg(8'hB0, 7'd127, 7'd0, 16'h0000);
        send_msg(8'hBF, 7'd127, 7'd1, 16'hFFFF);
        send_msg(8'hB5, 7'd127, 7'd63, 16'h5555);
        send_msg(8'hBA, 7'd127, 7'd64, 16'hAAAA);
        send_msg(8'hB3, 7'd127, 7'd126, 16'h0001);
        send_msg(8'hBC, 7'd127, 7'd127, 16'h8000);
    endtask

    task automatic test_channel_filter();
        settle();
        write_reg(CFG_LISTEN_CC, 28'd0);
        write_reg(CFG_LISTEN_CHANNEL, 28'd16);
        write_map(1, make_map(1'b0, 7'd9, 4'd1, 7'd0, 7'd127, CURVE_LINEAR));
        write_map(3, make_map(1'b0, 7'd9, 4'd1, 7'd0, 7'd127, CURVE_LINEAR));
        send_msg(8'hBF, 7'd0, 7'd100, 16'h0F0F);
        send_msg(8'hB0, 7'd0, 7'd100, 16'hF0F0);
        send_msg(8'hBF, 7'd1, 7'd100, 16'h00FF);
        settle();
        write_reg(CFG_LISTEN_CHANNEL, 28'hFFFFFE1);
        write_reg(8'd8, 28'hFFFFFFF);
        write_reg(8'd255, 28'h0000000);
        send_msg(8'hB0, 7'd0, 7'd33, 16'hFF00);
        settle();
        write_reg(CFG_LISTEN_CHANNEL, 28'd17);
        send_msg(8'hB0, 7'd0, 7'd77, 16'h1357);
        settle();
        write_reg(CFG_LISTEN_CHANNEL, 28'd31);
        send_msg(8'hBF, 7'd0, 7'd77, 16'h2468);
    endtask

    task automatic test_random_traffic(int snd_pct, int rcv_pct);
        int         hits;
        logic [7:0] status;
        logic [6:0] d1;
        t_map       m;
        for (int cfg_round = 0; cfg_round < 2; cfg_round++) begin
            settle();
            write_reg(CFG_LISTEN_CC, CFG_DATA_W'($urandom_range(127)));
            if ($urandom_range(1) == 0) begin
                write_reg(CFG_LISTEN_CHANNEL, CFG_DATA_W'(LISTEN_ANY));
            end else begin
                write_reg(CFG_LISTEN_CHANNEL, CFG_DATA_W'($urandom_range(16, 1)));
            end
            for (int s = 0; s < NUM_SLOTS_DEF; s++) begin
                m = t_map'(CFG_DATA_W'($urandom()));
                m.en = (cfg_round == 0) || ($urandom_range(99) < 75);
                write_map(s, m);
            end
            snd_idle_pct  = snd_pct;
            rcv_stall_pct = rcv_pct;
            hits = 0;
            while (hits < 36) begin
                if ($urandom_range(99) < 78) begin
                    if (listen_ch_q == LISTEN_ANY) begin
                        status = {CC_STATUS_HI, 4'($urandom_range(15))};
                    end else begin
                        status = {CC_STATUS_HI, 4'(listen_ch_q - 5'd1)};
                    end
                    d1 = listen_cc_q;
                    hits++;
                end else begin
                    status = 8'($urandom_range(255));
                    d1 = ($urandom_range(1) == 0) ? listen_cc_q : 7'($urandom_range(127));
                end
                send_msg(status, d1, 7'($urandom_range(127)), 16'($urandom_range(65535)));
            end
            snd_idle_pct  = 0;
            rcv_stall_pct = 0;
        end
    endtask

    initial begin
        listen_cc_q = LISTEN_CC_RESET;
        listen_ch_q = LISTEN_CHANNEL_RESET;
        for (int s = 0; s < NUM_SLOTS_DEF; s++) begin
            slot_map[s] = t_map'(MAP_RESET);
        end
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_pass_through();
        test_curve_shapes();
        test_channel_filter();
        test_random_traffic(0, 0);
        test_random_traffic(54, 0);
        test_random_traffic(0, 54);
        test_random_traffic(6, 6);

        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (30) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            flag_mismatch($sformatf("%0d results never arrived", pending_results.size()));
        end

        $display("Sent %0d messages and checked %0d macro transfers over %0d register settings,",
                 message_count, macro_count, setting_count);
        $display("with all four curve codes, the channel filter and idle or stall phases.");
        if (mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

`default_nettype wire
